[rtl/core/gdfs_pkg.sv]
// Package for the depth-first graph walk engine: field widths, size defaults,
// operation and status codes.
// No dependencies.
`timescale 1ns / 1ps

package gdfs_pkg;

  localparam int VTX_W        = 6;
  localparam int FUNC_W       = 2;
  localparam int STATUS_W     = 2;
  localparam int CNT_W        = 7;
  localparam int MAX_VERTICES = 64;
  localparam int MAX_DEGREE   = 8;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_WALK  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

endpackage

[rtl/core/graph_dfs_traversal_engine.sv]
// Add-edge: result from S_ADD_WB, or from S_ADD_WA when full; out-of-range adds and
// clears answer in the next cycle without raising busy. Unused selectors give nothing.
// Walk: each table entry tried passes S_SCAN and S_NBR, plus S_PUSH for an unvisited
// neighbor; each pop passes S_SCAN and S_POP, reading the neighbor, degree and stack RAMs.
// Results cannot be stalled. Reset clears control, sets the vertex count to 64, clears the degree
// counts and visited marks (valid bits in flops); RAM contents need no clearing pass.
`timescale 1ns / 1ps

module graph_dfs_traversal_engine #(
  parameter int MAX_V = gdfs_pkg::MAX_VERTICES,
  parameter int MAX_D = gdfs_pkg::MAX_DEGREE
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [gdfs_pkg::FUNC_W-1:0]   func_i,
  input  logic [gdfs_pkg::VTX_W-1:0]    vertex_a_i,
  input  logic [gdfs_pkg::VTX_W-1:0]    vertex_b_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [gdfs_pkg::CNT_W-1:0]    cfg_vertex_count_i,
  output logic                          result_valid_o,
  output logic [gdfs_pkg::VTX_W-1:0]    visited_vertex_o,
  output logic [gdfs_pkg::STATUS_W-1:0] status_o,
  output logic                          last_o
);

  localparam int VW      = gdfs_pkg::VTX_W;
  localparam int CW      = gdfs_pkg::CNT_W;
  localparam int DEG_W   = $clog2(MAX_D + 1);
  localparam int VAW     = $clog2(MAX_V);
  localparam int NBR_N   = MAX_V * MAX_D;
  localparam int NBR_AW  = $clog2(NBR_N);
  localparam int DEPTH_W = $clog2(MAX_V + 1);
  localparam int STK_W   = VW + DEG_W;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_ADD_RD  = 9'b000000010,
    S_ADD_WA  = 9'b000000100,
    S_ADD_WB  = 9'b000001000,
    S_WINIT   = 9'b000010000,
    S_SCAN    = 9'b000100000,
    S_NBR     = 9'b001000000,
    S_PUSH    = 9'b010000000,
    S_POP     = 9'b100000000
  } state_e;

  function automatic logic [NBR_AW-1:0] nbr_addr(input logic [VW-1:0] v,
                                                 input logic [DEG_W-1:0] idx);
    nbr_addr = NBR_AW'(NBR_AW'(v) * NBR_AW'(MAX_D) + NBR_AW'(idx));
  endfunction

  state_e            state_q, state_d;
  logic [VW-1:0]     va_q, va_d, vb_q, vb_d;
  logic [DEG_W-1:0]  deg_a_q, deg_a_d, deg_b_q, deg_b_d;
  logic [VW-1:0]     top_v_q, top_v_d, pend_q, pend_d, w_q, w_d;
  logic [DEG_W-1:0]  top_rem_q, top_rem_d;
  logic [DEPTH_W-1:0] depth_q, depth_d;
  logic [MAX_V-1:0]  visited_q, visited_d, deg_valid_q, deg_valid_d;
  logic              deg_ok_q, deg_ok_d;
  logic [CW-1:0]     vcount_q;
  logic              res_valid_q, res_valid_d, res_last_q, res_last_d;
  logic [VW-1:0]     res_vertex_q, res_vertex_d;
  gdfs_pkg::status_e res_status_q, res_status_d;

  logic              accept;
  logic [CW-1:0]     eff_n;
  logic              a_oor, b_oor;

  logic              nbr_we;
  logic [NBR_AW-1:0] nbr_waddr, nbr_raddr;
  logic [VW-1:0]     nbr_wdata, nbr_rdata;
  logic              deg_we;
  logic [VAW-1:0]    deg_waddr, deg_raddr;
  logic [DEG_W-1:0]  deg_wdata, deg_rdata, deg_rd;
  logic              stk_we;
  logic [VAW-1:0]    stk_waddr, stk_raddr;
  logic [STK_W-1:0]  stk_wdata, stk_rdata;

  logic [DEG_W:0]    da_plus2;
  logic              self_loop, table_full;
  logic [DEG_W-1:0]  db_eff, rem_dec;
  logic [DEPTH_W-1:0] depth_m1, depth_m2;

  assign accept      = start && !busy;
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign eff_n       = (vcount_q > CW'(MAX_V)) ? CW'(MAX_V) : vcount_q;
  assign a_oor       = ({1'b0, vertex_a_i} >= eff_n);
  assign b_oor       = ({1'b0, vertex_b_i} >= eff_n);
  assign deg_rd      = deg_ok_q ? deg_rdata : '0;
  assign self_loop   = (va_q == vb_q);
  assign da_plus2    = (DEG_W + 1)'(deg_a_q) + (DEG_W + 1)'(2);
  assign table_full  = self_loop ? (da_plus2 > (DEG_W + 1)'(MAX_D))
                                 : ((deg_a_q >= DEG_W'(MAX_D)) || (deg_rd >= DEG_W'(MAX_D)));
  assign db_eff      = self_loop ? DEG_W'(deg_a_q + DEG_W'(1)) : deg_b_q;
  assign rem_dec     = top_rem_q - DEG_W'(1);
  assign depth_m1    = depth_q - DEPTH_W'(1);
  assign depth_m2    = depth_q - DEPTH_W'(2);

  always_comb begin
    state_d      = state_q;
    va_d         = va_q;
    vb_d         = vb_q;
    deg_a_d      = deg_a_q;
    deg_b_d      = deg_b_q;
    top_v_d      = top_v_q;
    top_rem_d    = top_rem_q;
    pend_d       = pend_q;
    w_d          = w_q;
    depth_d      = depth_q;
    visited_d    = visited_q;
    deg_valid_d  = deg_valid_q;
    res_valid_d  = 1'b0;
    res_last_d   = 1'b0;
    res_vertex_d = '0;
    res_status_d = gdfs_pkg::ST_OK;
    nbr_we       = 1'b0;
    nbr_waddr    = '0;
    nbr_wdata    = '0;
    nbr_raddr    = '0;
    deg_we       = 1'b0;
    deg_waddr    = '0;
    deg_wdata    = '0;
    deg_raddr    = '0;
    stk_we       = 1'b0;
    stk_waddr    = depth_m1[VAW-1:0];
    stk_wdata    = {top_v_q, top_rem_q};
    stk_raddr    = depth_m2[VAW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          va_d = vertex_a_i;
          vb_d = vertex_b_i;
          unique case (gdfs_pkg::func_e'(func_i))
            gdfs_pkg::FUNC_ADD: begin
              if (a_oor || b_oor) begin
                res_valid_d  = 1'b1;
                res_last_d   = 1'b1;
                res_status_d = gdfs_pkg::ST_RANGE;
              end else begin
                deg_raddr = vertex_a_i[VAW-1:0];
                state_d   = S_ADD_RD;
              end
            end
            gdfs_pkg::FUNC_WALK: begin
              if (a_oor) begin
                res_valid_d  = 1'b1;
                res_last_d   = 1'b1;
                res_status_d = gdfs_pkg::ST_RANGE;
              end else begin
                deg_raddr                      = vertex_a_i[VAW-1:0];
                visited_d                      = '0;
                visited_d[vertex_a_i[VAW-1:0]] = 1'b1;
                state_d                        = S_WINIT;
              end
            end
            gdfs_pkg::FUNC_CLEAR: begin
              deg_valid_d = '0;
              res_valid_d = 1'b1;
              res_last_d  = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_ADD_RD: begin
        deg_a_d   = deg_rd;
        deg_raddr = vb_q[VAW-1:0];
        state_d   = S_ADD_WA;
      end
      S_ADD_WA: begin
        deg_b_d = deg_rd;
        if (table_full) begin
          res_valid_d  = 1'b1;
          res_last_d   = 1'b1;
          res_status_d = gdfs_pkg::ST_FULL;
          state_d      = S_IDLE;
        end else begin
          nbr_we                   = 1'b1;
          nbr_waddr                = nbr_addr(va_q, deg_a_q);
          nbr_wdata                = vb_q;
          deg_we                   = 1'b1;
          deg_waddr                = va_q[VAW-1:0];
          deg_wdata                = deg_a_q + DEG_W'(1);
          deg_valid_d[va_q[VAW-1:0]] = 1'b1;
          state_d                  = S_ADD_WB;
        end
      end
      S_ADD_WB: begin
        nbr_we                   = 1'b1;
        nbr_waddr                = nbr_addr(vb_q, db_eff);
        nbr_wdata                = va_q;
        deg_we                   = 1'b1;
        deg_waddr                = vb_q[VAW-1:0];
        deg_wdata                = db_eff + DEG_W'(1);
        deg_valid_d[vb_q[VAW-1:0]] = 1'b1;
        res_valid_d              = 1'b1;
        res_last_d               = 1'b1;
        state_d                  = S_IDLE;
      end
      S_WINIT: begin
        top_v_d   = va_q;
        top_rem_d = deg_rd;
        pend_d    = va_q;
        depth_d   = DEPTH_W'(1);
        state_d   = S_SCAN;
      end
      S_SCAN: begin
        if (top_rem_q == '0) begin
          if (depth_q == DEPTH_W'(1)) begin
            res_valid_d  = 1'b1;
            res_last_d   = 1'b1;
            res_vertex_d = pend_q;
            depth_d      = '0;
            state_d      = S_IDLE;
          end else begin
            depth_d = depth_m1;
            state_d = S_POP;
          end
        end else begin
          top_rem_d = rem_dec;
          nbr_raddr = nbr_addr(top_v_q, rem_dec);
          state_d   = S_NBR;
        end
      end
      S_NBR: begin
        if (!visited_q[nbr_rdata[VAW-1:0]]) begin
          visited_d[nbr_rdata[VAW-1:0]] = 1'b1;
          deg_raddr                     = nbr_rdata[VAW-1:0];
          w_d                           = nbr_rdata;
          state_d                       = S_PUSH;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_PUSH: begin
        res_valid_d  = 1'b1;
        res_vertex_d = pend_q;
        pend_d       = w_q;
        stk_we       = 1'b1;
        top_v_d      = w_q;
        top_rem_d    = deg_rd;
        depth_d      = depth_q + DEPTH_W'(1);
        state_d      = S_SCAN;
      end
      S_POP: begin
        top_v_d   = stk_rdata[STK_W-1:DEG_W];
        top_rem_d = stk_rdata[DEG_W-1:0];
        state_d   = S_SCAN;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign deg_ok_d = deg_valid_d[deg_raddr] && deg_valid_q[deg_raddr];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      depth_q     <= '0;
      visited_q   <= '0;
      deg_valid_q <= '0;
      deg_ok_q    <= 1'b0;
      vcount_q    <= CW'(64);
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      depth_q     <= depth_d;
      visited_q   <= visited_d;
      deg_valid_q <= deg_valid_d;
      deg_ok_q    <= deg_ok_d;
      res_valid_q <= res_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        vcount_q <= cfg_vertex_count_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    va_q         <= va_d;
    vb_q         <= vb_d;
    deg_a_q      <= deg_a_d;
    deg_b_q      <= deg_b_d;
    top_v_q      <= top_v_d;
    top_rem_q    <= top_rem_d;
    pend_q       <= pend_d;
    w_q          <= w_d;
    res_last_q   <= res_last_d;
    res_vertex_q <= res_vertex_d;
    res_status_q <= res_status_d;
  end

  gdfs_ram #(.WIDTH(VW), .DEPTH(NBR_N)) u_nbr_ram (
    .clk_i   (clk_i),
    .we_i    (nbr_we),
    .waddr_i (nbr_waddr),
    .wdata_i (nbr_wdata),
    .raddr_i (nbr_raddr),
    .rdata_o (nbr_rdata)
  );

  gdfs_ram #(.WIDTH(DEG_W), .DEPTH(MAX_V)) u_deg_ram (
    .clk_i   (clk_i),
    .we_i    (deg_we),
    .waddr_i (deg_waddr),
    .wdata_i (deg_wdata),
    .raddr_i (deg_raddr),
    .rdata_o (deg_rdata)
  );

  gdfs_ram #(.WIDTH(STK_W), .DEPTH(MAX_V)) u_stk_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  assign result_valid_o   = res_valid_q;
  assign visited_vertex_o = res_vertex_q;
  assign status_o         = res_status_q;
  assign last_o           = res_last_q;

endmodule

[rtl/core/gdfs_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module gdfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/gdfs_checker.sv]
// Port-level checker for the depth-first graph walk engine, bound to the top level.
// Depends on gdfs_pkg for widths and codes.
`timescale 1ns / 1ps

module gdfs_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic [gdfs_pkg::FUNC_W-1:0]   func_i,
  input logic                          result_valid_o,
  input logic [gdfs_pkg::VTX_W-1:0]    visited_vertex_o,
  input logic [gdfs_pkg::STATUS_W-1:0] status_o,
  input logic                          last_o
);

  a_error_is_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (status_o != gdfs_pkg::ST_OK) |-> last_o && (visited_vertex_o == '0))
    else $error("Error result is not a lone final transaction.");

  a_mid_walk_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |-> busy)
    else $error("Walk result without last while the engine is idle.");

  a_unused_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (func_i == gdfs_pkg::FUNC_NONE) |=> !busy && !result_valid_o)
    else $error("Unused selector caused activity.");

  a_clear_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (func_i == gdfs_pkg::FUNC_CLEAR)
      |=> result_valid_o && last_o && (status_o == gdfs_pkg::ST_OK) && !busy)
    else $error("Clear did not answer in the next cycle.");

endmodule

bind graph_dfs_traversal_engine gdfs_checker u_gdfs_checker (.*);

[test/graph_dfs_checker.sv]
// Checker for the depth-first graph walk engine: watches the command, configuration and
// result channels, predicts every result in order and compares field by field.
// Depends on gdfs_pkg.
`timescale 1ns / 1ps

module graph_dfs_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          busy_i,
  input  logic [gdfs_pkg::FUNC_W-1:0]   func_i,
  input  logic [gdfs_pkg::VTX_W-1:0]    vertex_a_i,
  input  logic [gdfs_pkg::VTX_W-1:0]    vertex_b_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [gdfs_pkg::CNT_W-1:0]    cfg_vertex_count_i,
  input  logic                          result_valid_i,
  input  logic [gdfs_pkg::VTX_W-1:0]    visited_vertex_i,
  input  logic [gdfs_pkg::STATUS_W-1:0] status_i,
  input  logic                          last_i,
  output int                            mismatch_count_o,
  output int                            outstanding_o
);

  import gdfs_pkg::*;

  typedef struct packed {
    logic [VTX_W-1:0] vertex;
    status_e          status;
    logic             last;
  } engine_result_t;

  logic [VTX_W-1:0] nbr_tbl [MAX_VERTICES][MAX_DEGREE];
  logic [3:0]       degree [MAX_VERTICES];
  logic [CNT_W-1:0] vertex_count;
  engine_result_t   awaited_results [$];
  int               mismatches;

  assign mismatch_count_o = mismatches;

  function automatic int usable_vertices();
    return (vertex_count > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_count);
  endfunction

  function automatic status_e link_vertices(input logic [VTX_W-1:0] a, input logic [VTX_W-1:0] b);
    int n;
    n = usable_vertices();
    if (a >= n || b >= n) return ST_RANGE;
    if (a == b) begin
      if (degree[a] + 2 > MAX_DEGREE) return ST_FULL;
    end else if (degree[a] >= MAX_DEGREE || degree[b] >= MAX_DEGREE) begin
      return ST_FULL;
    end
    nbr_tbl[a][degree[a]] = b;
    degree[a] = degree[a] + 1'b1;
    nbr_tbl[b][degree[b]] = a;
    degree[b] = degree[b] + 1'b1;
    return ST_OK;
  endfunction

  // Each stack entry keeps a vertex and how many of its table entries are still untried;
  // entries are tried from the newest one down.
  task automatic walk_from(input logic [VTX_W-1:0] origin);
    logic [MAX_VERTICES-1:0] seen;
    logic [VTX_W-1:0]        stk_vertex [MAX_VERTICES];
    logic [3:0]              stk_left [MAX_VERTICES];
    int                      depth;
    logic [VTX_W-1:0]        v;
    logic [VTX_W-1:0]        w;
    logic [3:0]              left;
    engine_result_t          trail [$];
    seen = '0;
    seen[origin] = 1'b1;
    trail.push_back('{origin, ST_OK, 1'b0});
    stk_vertex[0] = origin;
    stk_left[0] = degree[origin];
    depth = 1;
    while (depth > 0) begin
      v = stk_vertex[depth-1];
      left = stk_left[depth-1];
      if (left == 0) begin
        depth--;
      end else begin
        left = left - 1'b1;
        stk_left[depth-1] = left;
        w = nbr_tbl[v][left[2:0]];
        if (!seen[w] && depth < MAX_VERTICES) begin
          seen[w] = 1'b1;
          trail.push_back('{w, ST_OK, 1'b0});
          stk_vertex[depth] = w;
          stk_left[depth] = degree[w];
          depth++;
        end
      end
    end
    trail[trail.size()-1].last = 1'b1;
    foreach (trail[i]) awaited_results.push_back(trail[i]);
  endtask

  task automatic predict_op(input func_e op, input logic [VTX_W-1:0] a,
                            input logic [VTX_W-1:0] b);
    case (op)
      FUNC_ADD: begin
        awaited_results.push_back('{'0, link_vertices(a, b), 1'b1});
      end
      FUNC_WALK: begin
        if (a >= usable_vertices()) awaited_results.push_back('{'0, ST_RANGE, 1'b1});
        else walk_from(a);
      end
      FUNC_CLEAR: begin
        foreach (degree[i]) degree[i] = '0;
        awaited_results.push_back('{'0, ST_OK, 1'b1});
      end
      default: begin
      end
    endcase
  endtask

  task automatic report_mismatch(input string detail);
    mismatches++;
    if (mismatches <= 10) $display("%0t mismatch: %s", $realtime, detail);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    engine_result_t want;
    if (!rst_ni) begin
      foreach (degree[i]) degree[i] = '0;
      vertex_count = 7'd64;
      awaited_results.delete();
      mismatches = 0;
      outstanding_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) vertex_count = cfg_vertex_count_i;
      if (start_i && !busy_i) predict_op(func_e'(func_i), vertex_a_i, vertex_b_i);
      if (result_valid_i) begin
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result vertex %0d status %0d last %0d",
                                    visited_vertex_i, status_i, last_i));
        end else begin
          want = awaited_results.pop_front();
          if (visited_vertex_i !== want.vertex || status_i !== want.status ||
              last_i !== want.last) begin
            report_mismatch($sformatf(
                "expected vertex %0d status %0d last %0d, got vertex %0d status %0d last %0d",
                want.vertex, want.status, want.last, visited_vertex_i, status_i, last_i));
          end
        end
      end
      outstanding_o <= awaited_results.size();
    end
  end

endmodule

[test/graph_dfs_traversal_engine_test.sv]
// Top of the testbench for the depth-first graph walk engine: clock, reset, directed and
// random commands, vertex count writes, watchdog and verdict.
// Depends on gdfs_pkg, graph_dfs_traversal_engine and graph_dfs_checker.
`timescale 1ns / 1ps

module graph_dfs_traversal_engine_test;

  import gdfs_pkg::*;

  localparam int QUIET_LIMIT = 20000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [FUNC_W-1:0]   func_i = '0;
  logic [VTX_W-1:0]    vertex_a_i = '0;
  logic [VTX_W-1:0]    vertex_b_i = '0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CNT_W-1:0]    cfg_vertex_count_i = '0;
  logic                result_valid_o;
  logic [VTX_W-1:0]    visited_vertex_o;
  logic [STATUS_W-1:0] status_o;
  logic                last_o;
  int                  mismatch_count;
  int                  outstanding;
  int                  quiet_cycles = 0;
  bit                  allow_gaps = 1'b1;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  graph_dfs_traversal_engine DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .func_i             (func_i),
    .vertex_a_i         (vertex_a_i),
    .vertex_b_i         (vertex_b_i),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_vertex_count_i (cfg_vertex_count_i),
    .result_valid_o     (result_valid_o),
    .visited_vertex_o   (visited_vertex_o),
    .status_o           (status_o),
    .last_o             (last_o)
  );

  graph_dfs_checker dfs_check (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start),
    .busy_i             (busy),
    .func_i             (func_i),
    .vertex_a_i         (vertex_a_i),
    .vertex_b_i         (vertex_b_i),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_i        (cfg_ready_o),
    .cfg_vertex_count_i (cfg_vertex_count_i),
    .result_valid_i     (result_valid_o),
    .visited_vertex_i   (visited_vertex_o),
    .status_i           (status_o),
    .last_i             (last_o),
    .mismatch_count_o   (mismatch_count),
    .outstanding_o      (outstanding)
  );

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_op(input func_e f, input logic [VTX_W-1:0] a, input logic [VTX_W-1:0] b);
    if (allow_gaps && $urandom_range(3) == 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat ($urandom_range(1, 12) - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start <= 1'b1;
    func_i <= f;
    vertex_a_i <= a;
    vertex_b_i <= b;
    do @(posedge clk_i); while (busy);
  endtask

  // Waits until every predicted result has come and the engine has dropped busy.
  task automatic wait_quiet();
    @(negedge clk_i);
    start <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0 || busy) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_vertex_count(input logic [CNT_W-1:0] count);
    wait_quiet();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_vertex_count_i <= count;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [CNT_W-1:0] phase_count [9];
    int               eff;
    int               span;
    int               done;
    int               pick;
    logic [VTX_W-1:0] a;
    logic [VTX_W-1:0] b;
    func_e            f;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_op(FUNC_CLEAR, 6'd0, 6'd0);
    send_op(FUNC_NONE, 6'd5, 6'd9);
    send_op(FUNC_ADD, 6'd0, 6'd63);
    send_op(FUNC_ADD, 6'd63, 6'd63);
    send_op(FUNC_ADD, 6'd0, 6'd1);
    send_op(FUNC_ADD, 6'd1, 6'd62);
    send_op(FUNC_WALK, 6'd0, 6'd63);
    send_op(FUNC_WALK, 6'd63, 6'd0);
    for (int i = 10; i < 17; i++) send_op(FUNC_ADD, 6'd2, i[5:0]);
    // A self-loop needs two free slots; vertex 2 has only one left here.
    send_op(FUNC_ADD, 6'd2, 6'd2);
    send_op(FUNC_ADD, 6'd2, 6'd17);
    send_op(FUNC_ADD, 6'd2, 6'd18);
    send_op(FUNC_WALK, 6'd2, 6'd0);

    // With the count lowered, stored edges to higher vertices are still followed.
    write_vertex_count(7'd1);
    send_op(FUNC_ADD, 6'd0, 6'd0);
    send_op(FUNC_ADD, 6'd0, 6'd1);
    send_op(FUNC_ADD, 6'd1, 6'd0);
    send_op(FUNC_WALK, 6'd0, 6'd0);
    send_op(FUNC_WALK, 6'd1, 6'd0);
    write_vertex_count(7'd0);
    send_op(FUNC_WALK, 6'd0, 6'd0);

    phase_count[0] = 7'd127;
    phase_count[1] = CNT_W'($urandom_range(2, 16));
    phase_count[2] = 7'd64;
    phase_count[3] = CNT_W'($urandom_range(17, 63));
    phase_count[4] = 7'd1;
    phase_count[5] = CNT_W'($urandom_range(65, 126));
    phase_count[6] = CNT_W'($urandom_range(2, 12));
    phase_count[7] = 7'd0;
    phase_count[8] = 7'd64;

    for (int p = 0; p < 9; p++) begin
      write_vertex_count(phase_count[p]);
      allow_gaps = (p != 8) && ($urandom_range(2) != 0);
      eff = (phase_count[p] > MAX_VERTICES) ? MAX_VERTICES : int'(phase_count[p]);
      span = (eff > 16) ? int'($urandom_range(8, eff)) : eff;
      if ($urandom_range(1) != 0) begin
        send_op(FUNC_CLEAR, VTX_W'($urandom_range(63)), VTX_W'($urandom_range(63)));
      end
      done = 0;
      while (done < ((eff == 0) ? 10 : (eff == 1) ? 20 : 43)) begin
        pick = $urandom_range(99);
        a = VTX_W'($urandom_range(63));
        b = VTX_W'($urandom_range(63));
        f = FUNC_ADD;
        if (pick < 55) begin
          if (span > 0 && $urandom_range(19) != 0) begin
            a = VTX_W'($urandom_range(span - 1));
            b = VTX_W'($urandom_range(span - 1));
          end
        end else if (pick < 80) begin
          f = FUNC_WALK;
          if (span > 0 && $urandom_range(9) != 0) a = VTX_W'($urandom_range(span - 1));
        end else if (pick < 87) begin
          f = FUNC_CLEAR;
        end else if (pick < 92) begin
          f = FUNC_NONE;
        end else if (pick[0]) begin
          f = FUNC_WALK;
        end
        send_op(f, a, b);
        if (f != FUNC_NONE) done++;
      end
    end

    wait_quiet();
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
